/* design/i2cm_pkg.sv */
// Shared command codes, phase table and status type for the I2C master engine.
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;
    localparam logic [2:0] ACT_ACK   = 3'd5;
    localparam logic [2:0] ACT_NACK  = 3'd6;
    localparam logic [2:0] ACT_WAIT  = 3'd7;

    localparam logic [4:0] STEP_IDLE = 5'd31;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack;
    } i2cm_status_t;

    function automatic logic [4:0] phase_total(input logic [2:0] cmd);
        logic [4:0] total;
        unique case (cmd)
            ACT_START: total = 5'd3;
            ACT_STOP:  total = 5'd2;
            ACT_WRITE: total = 5'd16;
            ACT_READ:  total = 5'd16;
            ACT_ACK:   total = 5'd4;
            ACT_NACK:  total = 5'd3;
            ACT_WAIT:  total = 5'd2;
            default:   total = 5'd0;
        endcase
        return total;
    endfunction

endpackage

`default_nettype wire

/* design/i2cm_seq.sv */
// Phase sequencer of the I2C master engine: command state, tick counter and pins.
`default_nettype none

module i2cm_seq #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     tick_en,
    input  wire logic [2:0]               action,
    input  wire logic [7:0]               write_data,
    input  wire logic                     sda_level,
    input  wire logic [COUNT_WIDTH-1:0]   limit,
    output i2cm_pkg::i2cm_status_t        status_next
);
    import i2cm_pkg::*;

    typedef struct packed {
        logic scl;
        logic sda;
    } pins_t;

    logic [4:0]             step_reg, step_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [7:0]             shift_reg, shift_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   ack_reg, ack_next;
    logic [7:0]             read_reg, read_next;
    logic                   done;
    logic [4:0]             step_inc;
    pins_t                  pins;

    function automatic pins_t begin_pins(input logic [2:0] cmd, input logic [4:0] s,
                                         input pins_t cur, input logic bit7);
        pins_t p;
        p = cur;
        unique case (cmd)
            ACT_START: begin
                if (s == 5'd0) begin
                    p.sda = 1'b1;
                    p.scl = 1'b1;
                end else if (s == 5'd1) begin
                    p.sda = 1'b0;
                end else begin
                    p.scl = 1'b0;
                end
            end
            ACT_STOP: begin
                if (s == 5'd0) begin
                    p.sda = 1'b0;
                    p.scl = 1'b1;
                end else begin
                    p.sda = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (!s[0]) begin
                    p.sda = bit7;
                    p.scl = 1'b1;
                end else begin
                    p.scl = 1'b0;
                end
            end
            ACT_READ: p.scl = !s[0];
            ACT_ACK: begin
                if (s == 5'd0) begin
                    p.sda = 1'b0;
                end else if (s == 5'd1) begin
                    p.scl = 1'b1;
                end else if (s == 5'd2) begin
                    p.scl = 1'b0;
                end else begin
                    p.sda = 1'b1;
                end
            end
            ACT_NACK: begin
                if (s == 5'd0) begin
                    p.sda = 1'b1;
                end else if (s == 5'd1) begin
                    p.scl = 1'b1;
                end else begin
                    p.scl = 1'b0;
                end
            end
            ACT_WAIT: begin
                if (s == 5'd0) begin
                    p.sda = 1'b1;
                    p.scl = 1'b1;
                end else begin
                    p.scl = 1'b0;
                end
            end
            default: p = cur;
        endcase
        return p;
    endfunction

    assign tick_inc = tick_reg + COUNT_WIDTH'(1);
    assign step_inc = step_reg + 5'd1;

    always_comb begin
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        read_next  = read_reg;
        done       = 1'b0;
        pins       = '{scl: scl_reg, sda: sda_reg};

        if (step_reg == STEP_IDLE) begin
            if (action != ACT_NONE) begin
                cmd_next  = action;
                step_next = 5'd0;
                tick_next = '0;
                if (action == ACT_WRITE) begin
                    shift_next = write_data;
                end else if (action == ACT_READ) begin
                    shift_next = 8'd0;
                end
                pins     = begin_pins(action, 5'd0, pins, shift_next[7]);
                scl_next = pins.scl;
                sda_next = pins.sda;
            end
        end else if (tick_inc >= limit) begin
            tick_next = '0;
            if (cmd_reg == ACT_WRITE && step_reg[0]) begin
                shift_next = {shift_reg[6:0], 1'b0};
                if (step_reg == 5'd15) begin
                    pins.sda = 1'b1;
                end
            end else if (cmd_reg == ACT_READ) begin
                if (!step_reg[0]) begin
                    shift_next = {shift_reg[6:0], sda_level};
                end else if (step_reg == 5'd15) begin
                    read_next = shift_reg;
                end
            end else if (cmd_reg == ACT_WAIT && step_reg == 5'd0) begin
                ack_next = sda_level;
            end
            if (step_inc >= phase_total(cmd_reg)) begin
                step_next = STEP_IDLE;
                done      = 1'b1;
            end else begin
                step_next = step_inc;
                pins      = begin_pins(cmd_reg, step_inc, pins, shift_next[7]);
            end
            scl_next = pins.scl;
            sda_next = pins.sda;
        end else begin
            tick_next = tick_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_IDLE;
            cmd_reg   <= ACT_NONE;
            tick_reg  <= '0;
            shift_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            read_reg  <= 8'd0;
        end else if (tick_en) begin
            step_reg  <= step_next;
            cmd_reg   <= cmd_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            read_reg  <= read_next;
        end
    end

    assign status_next.scl       = scl_next;
    assign status_next.sda       = sda_next;
    assign status_next.busy      = (step_next != STEP_IDLE);
    assign status_next.done      = done;
    assign status_next.read_data = read_next;
    assign status_next.ack       = ack_next;

endmodule

`default_nettype wire

/* design/i2c_master_bit_engine_top.sv */
// Top level of the I2C master engine: handshakes, phase length register, result register.
// An accepted input beat's result beat is registered and shown in the cycle after it is taken.
// One beat per cycle unless the result side stalls; the sequencer state and the result valid flag close the loops.
// The result register takes the next beat while the current one is taken.
// Reset is synchronous and active low; it idles the sequencer, releases both sequencer pins
// and sets the phase length to ten ticks; the result register itself is not reset.
`default_nettype none

module i2c_master_bit_engine_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [7:0]  s_write_data,
    input  wire logic        s_sda_level,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_scl_out,
    output logic             m_sda_out,
    output logic             m_busy_res,
    output logic             m_done_res,
    output logic [7:0]       m_read_data,
    output logic             m_ack_bit
);
    import i2cm_pkg::*;

    localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [15:0]            phase_ticks_reg;
    logic [LW-1:0]          ticks_ext;
    logic [LW-1:0]          max_ext;
    logic [COUNT_WIDTH-1:0] limit;
    logic                   accept;
    logic                   m_valid_reg, m_valid_next;
    i2cm_status_t           status_next;
    i2cm_status_t           status_reg;

    assign ticks_ext = LW'(phase_ticks_reg);
    assign max_ext   = LW'({COUNT_WIDTH{1'b1}});

    always_comb begin
        if (phase_ticks_reg == 16'd0) begin
            limit = COUNT_WIDTH'(1);
        end else if (ticks_ext > max_ext) begin
            limit = {COUNT_WIDTH{1'b1}};
        end else begin
            limit = COUNT_WIDTH'(ticks_ext);
        end
    end

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    i2cm_seq #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (accept),
        .action      (s_action),
        .write_data  (s_write_data),
        .sda_level   (s_sda_level),
        .limit       (limit),
        .status_next (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                phase_ticks_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl_out   = status_reg.scl;
    assign m_sda_out   = status_reg.sda;
    assign m_busy_res  = status_reg.busy;
    assign m_done_res  = status_reg.done;
    assign m_read_data = status_reg.read_data;
    assign m_ack_bit   = status_reg.ack;

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the I2C master bit engine: tick-by-tick pin and status prediction.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] wdata;
        logic       sda;
    } tick_beat_t;

    localparam int LONG_HOLD = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = ACT_NONE;
    logic [7:0]  s_write_data = 8'd0;
    logic        s_sda_level = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl_out;
    logic        m_sda_out;
    logic        m_busy_res;
    logic        m_done_res;
    logic [7:0]  m_read_data;
    logic        m_ack_bit;

    tick_beat_t   stim_q[$];
    i2cm_status_t status_q[$];

    logic [15:0] eng_ticks = PHASE_TICKS_RESET;
    logic [4:0]  eng_step = STEP_IDLE;
    logic [2:0]  eng_cmd = ACT_NONE;
    logic [15:0] eng_count = 16'd0;
    logic [7:0]  eng_shift = 8'd0;
    logic        eng_scl = 1'b1;
    logic        eng_sda = 1'b1;
    logic        eng_ack = 1'b0;
    logic [7:0]  eng_read_hold = 8'd0;

    int  errors = 0;
    int  beats_checked = 0;
    int  dones_seen = 0;
    int  cmds_taken = 0;
    int  ticks_sent = 0;
    int  items_made = 0;
    int  lim_now = 10;
    int  idle_left = 0;
    int  stall_left = 0;
    int  holds_asked = 0;
    int  holds_seen = 0;
    bit  no_gaps = 1'b0;

    i2c_master_bit_engine_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_write_data (s_write_data),
        .s_sda_level  (s_sda_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl_out    (m_scl_out),
        .m_sda_out    (m_sda_out),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_read_data  (m_read_data),
        .m_ack_bit    (m_ack_bit)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 2);
        end else if (r < 97) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [4:0] phase_count(input logic [2:0] cmd);
        case (cmd)
            ACT_START: return 5'd3;
            ACT_STOP:  return 5'd2;
            ACT_WRITE: return 5'd16;
            ACT_READ:  return 5'd16;
            ACT_ACK:   return 5'd4;
            ACT_NACK:  return 5'd3;
            ACT_WAIT:  return 5'd2;
            default:   return 5'd0;
        endcase
    endfunction

    task automatic apply_pins(input logic [2:0] cmd, input logic [4:0] s);
        case (cmd)
            ACT_START: begin
                if (s == 5'd0) begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end else if (s == 5'd1) begin
                    eng_sda = 1'b0;
                end else begin
                    eng_scl = 1'b0;
                end
            end
            ACT_STOP: begin
                if (s == 5'd0) begin
                    eng_sda = 1'b0;
                    eng_scl = 1'b1;
                end else begin
                    eng_sda = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (!s[0]) begin
                    eng_sda = eng_shift[7];
                    eng_scl = 1'b1;
                end else begin
                    eng_scl = 1'b0;
                end
            end
            ACT_READ: eng_scl = !s[0];
            ACT_ACK: begin
                if (s == 5'd0) begin
                    eng_sda = 1'b0;
                end else if (s == 5'd1) begin
                    eng_scl = 1'b1;
                end else if (s == 5'd2) begin
                    eng_scl = 1'b0;
                end else begin
                    eng_sda = 1'b1;
                end
            end
            ACT_NACK: begin
                if (s == 5'd0) begin
                    eng_sda = 1'b1;
                end else if (s == 5'd1) begin
                    eng_scl = 1'b1;
                end else begin
                    eng_scl = 1'b0;
                end
            end
            ACT_WAIT: begin
                if (s == 5'd0) begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end else begin
                    eng_scl = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic close_phase(input logic [2:0] cmd, input logic [4:0] s, input logic sda_in);
        if (cmd == ACT_WRITE && s[0]) begin
            eng_shift = {eng_shift[6:0], 1'b0};
            if (s == 5'd15) begin
                eng_sda = 1'b1;
            end
        end else if (cmd == ACT_READ) begin
            if (!s[0]) begin
                eng_shift = {eng_shift[6:0], sda_in};
            end else if (s == 5'd15) begin
                eng_read_hold = eng_shift;
            end
        end else if (cmd == ACT_WAIT && s == 5'd0) begin
            eng_ack = sda_in;
        end
    endtask

    task automatic engine_tick(input logic [2:0] act, input logic [7:0] wd, input logic sda_in);
        i2cm_status_t st;
        logic [16:0]  lim;
        logic         fin;
        fin = 1'b0;
        if (eng_step == STEP_IDLE) begin
            if (act != ACT_NONE) begin
                eng_cmd = act;
                eng_step = 5'd0;
                eng_count = 16'd0;
                if (act == ACT_WRITE) begin
                    eng_shift = wd;
                end else if (act == ACT_READ) begin
                    eng_shift = 8'd0;
                end
                apply_pins(eng_cmd, 5'd0);
                cmds_taken++;
            end
        end else begin
            lim = (eng_ticks == 16'd0) ? 17'd1 : {1'b0, eng_ticks};
            eng_count = eng_count + 16'd1;
            if ({1'b0, eng_count} >= lim) begin
                close_phase(eng_cmd, eng_step, sda_in);
                eng_count = 16'd0;
                if (({1'b0, eng_step} + 6'd1) >= {1'b0, phase_count(eng_cmd)}) begin
                    eng_step = STEP_IDLE;
                    fin = 1'b1;
                end else begin
                    eng_step = eng_step + 5'd1;
                    apply_pins(eng_cmd, eng_step);
                end
            end
        end
        st.scl = eng_scl;
        st.sda = eng_sda;
        st.busy = (eng_step != STEP_IDLE);
        st.done = fin;
        st.read_data = eng_read_hold;
        st.ack = eng_ack;
        status_q.push_back(st);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        tick_beat_t beat;
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                engine_tick(s_action, s_write_data, s_sda_level);
                ticks_sent++;
            end
            if (!s_valid || s_ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    beat = stim_q.pop_front();
                    s_valid <= 1'b1;
                    s_action <= beat.action;
                    s_write_data <= beat.wdata;
                    s_sda_level <= beat.sda;
                    idle_left = no_gaps ? 0 : gap_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (holds_seen != holds_asked) begin
                holds_seen = holds_asked;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = no_gaps ? 0 : gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        i2cm_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, actual scl %0b sda %0b",
                         $time, m_scl_out, m_sda_out);
                errors++;
            end else begin
                want = status_q.pop_front();
                check_field("scl_out", 8'(want.scl), 8'(m_scl_out));
                check_field("sda_out", 8'(want.sda), 8'(m_sda_out));
                check_field("busy_res", 8'(want.busy), 8'(m_busy_res));
                check_field("done_res", 8'(want.done), 8'(m_done_res));
                check_field("read_data", want.read_data, m_read_data);
                check_field("ack_bit", 8'(want.ack), 8'(m_ack_bit));
                beats_checked++;
                if (m_done_res) begin
                    dones_seen++;
                end
            end
        end
    end

    function automatic logic pick_sda(input int mode);
        if (mode == 0) begin
            return 1'b0;
        end else if (mode == 1) begin
            return 1'b1;
        end
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic push_item(input logic [2:0] act, input logic [7:0] wd, input logic sda,
                             input bit counted);
        while (stim_q.size() >= 16) begin
            @(negedge aclk);
        end
        stim_q.push_back('{act, wd, sda});
        if (counted) begin
            items_made++;
        end
    endtask

    task automatic run_command(input logic [2:0] cmd, input logic [7:0] wd, input int sda_mode,
                               input int noise);
        int n;
        n = int'(phase_count(cmd)) * lim_now;
        push_item(cmd, wd, pick_sda(sda_mode), 1'b1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise) begin
                push_item(3'($urandom_range(1, 7)), 8'($urandom), pick_sda(sda_mode), 1'b0);
            end else begin
                push_item(ACT_NONE, 8'($urandom), pick_sda(sda_mode), 1'b1);
            end
        end
    endtask

    task automatic idle_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            push_item(ACT_NONE, 8'($urandom), pick_sda(2), 1'b0);
        end
    endtask

    task automatic drain();
        do begin
            @(negedge aclk);
        end while (stim_q.size() != 0 || s_valid || status_q.size() != 0);
    endtask

    task automatic set_ticks(input logic [15:0] v);
        drain();
        repeat (2) @(negedge aclk);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        eng_ticks = v;
        lim_now = (v == 16'd0) ? 1 : int'(v);
        @(negedge aclk);
    endtask

    task automatic random_transaction();
        logic [7:0] addr;
        int         n;
        if ($urandom_range(0, 9) < 7) begin
            addr = 8'($urandom);
            n = $urandom_range(1, 3);
            run_command(ACT_START, 8'($urandom), 2, 3);
            run_command(ACT_WRITE, addr, 2, 3);
            run_command(ACT_WAIT, 8'($urandom), 2, 3);
            for (int i = 0; i < n; i++) begin
                if (addr[0]) begin
                    run_command(ACT_READ, 8'($urandom), 2, 3);
                    run_command((i == n - 1) ? ACT_NACK : ACT_ACK, 8'($urandom), 2, 3);
                end else begin
                    run_command(ACT_WRITE, 8'($urandom), 2, 3);
                    run_command(ACT_WAIT, 8'($urandom), 2, 3);
                end
            end
            run_command(ACT_STOP, 8'($urandom), 2, 3);
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                run_command(3'($urandom_range(1, 7)), 8'($urandom), 2, 10);
            end
        end
        idle_ticks($urandom_range(0, 3));
    endtask

    initial begin
        logic [15:0] settings[5];
        int          phase_end;
        settings = '{16'd2, 16'd1, 16'd0, 16'd3, 16'd6};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_command(ACT_STOP, 8'h5A, 2, 0);
        set_ticks(16'd1);
        idle_ticks(2);
        run_command(ACT_START, 8'h00, 2, 0);
        run_command(ACT_WRITE, 8'hFF, 0, 0);
        run_command(ACT_WAIT, 8'h00, 0, 0);
        run_command(ACT_WRITE, 8'h00, 1, 100);
        run_command(ACT_WAIT, 8'hFF, 1, 0);
        run_command(ACT_READ, 8'hA5, 1, 0);
        run_command(ACT_ACK, 8'h00, 2, 0);
        run_command(ACT_READ, 8'h5A, 0, 100);
        run_command(ACT_NACK, 8'h00, 2, 0);
        idle_ticks(2);
        run_command(ACT_STOP, 8'h00, 2, 0);

        foreach (settings[k]) begin
            set_ticks(settings[k]);
            if (k == 1) begin
                holds_asked++;
            end
            phase_end = items_made + 150;
            while (items_made < phase_end) begin
                random_transaction();
                if ($urandom_range(0, 7) == 0) begin
                    drain();
                end
            end
        end

        set_ticks(16'hFFFF);
        no_gaps = 1'b1;
        push_item(ACT_STOP, 8'($urandom), pick_sda(2), 1'b1);
        idle_ticks(40);
        drain();
        no_gaps = 1'b0;
        set_ticks(PHASE_TICKS_RESET);
        run_command(ACT_STOP, 8'($urandom), 2, 0);

        drain();
        repeat (4) @(posedge aclk);
        if (status_q.size() != 0) begin
            $display("%0t ns: %0d expected result beats never arrived", $time, status_q.size());
        end
        $display("Checked %0d result beats over %0d ticks: %0d commands taken, %0d completed.",
                 beats_checked, ticks_sent, cmds_taken, dones_seen);
        $display("Phase lengths 0 to 65535, bus transactions, broken orders, busy commands.");
        if (errors == 0 && status_q.size() == 0) begin
            $display("[i2c_master_bit_engine_top] OK");
        end else begin
            $display("[i2c_master_bit_engine_top] ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t ns: run did not finish in time", $time);
        $display("[i2c_master_bit_engine_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
